FILE: rtl/core/hcim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcim_pkg
// Payload types and field widths shared by the Hilbert curve index mapper.
// ----------------------------------------------------------------------------
package hcim_pkg;

    localparam int ORDER_W = 4;
    localparam int COORD_W = 8;
    localparam int INDEX_W = 16;

    typedef enum logic
    {
        OP_TO_POINT = 1'b0,
        OP_TO_INDEX = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                op;
        logic [INDEX_W-1:0] curve_index;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } req_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] x_out;
        logic [COORD_W-1:0] y_out;
        logic [INDEX_W-1:0] index_out;
        logic               valid_res;
    } rsp_t;

endpackage

FILE: rtl/core/hcim_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcim channel interfaces
// Valid/ready channels for requests, results and the order register write.
// ----------------------------------------------------------------------------
interface hcim_req_if;
    logic          valid;
    logic          ready;
    hcim_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcim_rsp_if;
    logic          valid;
    logic          ready;
    hcim_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcim_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hcim_pkg::ORDER_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/hilbert_curve_index_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_curve_index_mapper
// Maps Hilbert curve positions to grid cells and back, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transfer. With op OP_TO_POINT the curve_index
//   is mapped to a cell (x_out, y_out); with OP_TO_INDEX the cell
//   (x_coord, y_coord) is mapped to its curve position index_out. Inputs
//   beyond the grid or the curve length give an all-zero result with
//   valid_res low. rsp delivers exactly one result per request, in order.
//   cfg writes the curve order; values are saturated to 1..MAX_ORDER. It is
//   always ready and should only be written while no request is in flight.
// Timing:
//   A request is held in the input register, and the level-by-level mapping
//   logic loads its result into the result register, from which it is taken.
//   One request is taken every cycle while rsp is not stalled, as the
//   MAX_ORDER quadrant steps run as a single pass between those two registers.
// Reset and stall:
//   Reset empties both stages and sets the order to 8 (or MAX_ORDER if
//   smaller). When rsp is stalled the result holds, the input register fills,
//   and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module hilbert_curve_index_mapper #(
    parameter int MAX_ORDER = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    hcim_cfg_if.sink cfg,
    hcim_req_if.sink req,
    hcim_rsp_if.source rsp
);

    localparam int KW        = $clog2(MAX_ORDER + 1);
    localparam int CW        = MAX_ORDER;
    localparam int DW        = 2 * MAX_ORDER;
    localparam int RST_ORDER = (MAX_ORDER < 8) ? MAX_ORDER : 8;

    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  k_next;
    logic           s1_valid_reg;
    hcim_pkg::req_t s1_reg;
    logic           out_valid_reg;
    hcim_pkg::rsp_t out_reg;
    hcim_pkg::rsp_t res_next;
    logic           adv_out;

    assign cfg.ready = 1'b1;
    assign adv_out   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || adv_out;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        int unsigned v;
        v = int'(cfg.data);
        if (v < 1)
        begin
            k_next = KW'(1);
        end
        else if (v > MAX_ORDER)
        begin
            k_next = KW'(MAX_ORDER);
        end
        else
        begin
            k_next = KW'(v);
        end
    end

    // The mapping walks one quadrant level per step. Levels at or above the
    // current order are skipped.
    always_comb
    begin
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] t;
        logic [DW-1:0] didx;
        logic [DW-1:0] d;
        logic [1:0]    dig;
        logic          qa;
        logic          qb;
        logic          ok;
        int            kk;

        kk       = int'(k_reg);
        a        = '0;
        b        = '0;
        t        = '0;
        d        = '0;
        dig      = '0;
        qa       = 1'b0;
        qb       = 1'b0;
        ok       = 1'b1;
        didx     = DW'(s1_reg.curve_index);
        res_next = '0;

        if (s1_reg.op == hcim_pkg::OP_TO_POINT)
        begin
            for (int p = 0; p < hcim_pkg::INDEX_W; p++)
            begin
                if (p >= 2 * kk && s1_reg.curve_index[p])
                begin
                    ok = 1'b0;
                end
            end
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                if (i < kk)
                begin
                    dig = didx[2*i +: 2];
                    qa  = dig[1];
                    qb  = dig[0] ^ dig[1];
                    if (!qb)
                    begin
                        // Only the i low bits are filled so far; reflect those.
                        if (qa)
                        begin
                            a = a ^ ({CW{1'b1}} >> (CW - i));
                            b = b ^ ({CW{1'b1}} >> (CW - i));
                        end
                        t = a;
                        a = b;
                        b = t;
                    end
                    a[i] = a[i] | qa;
                    b[i] = b[i] | qb;
                end
            end
            if (ok)
            begin
                res_next.x_out     = hcim_pkg::COORD_W'(b);
                res_next.y_out     = hcim_pkg::COORD_W'(a);
                res_next.valid_res = 1'b1;
            end
        end
        else
        begin
            for (int p = 0; p < hcim_pkg::COORD_W; p++)
            begin
                if (p >= kk && (s1_reg.x_coord[p] || s1_reg.y_coord[p]))
                begin
                    ok = 1'b0;
                end
            end
            a = CW'(s1_reg.y_coord);
            b = CW'(s1_reg.x_coord);
            for (int j = MAX_ORDER - 1; j >= 0; j--)
            begin
                if (j < kk)
                begin
                    qa           = a[j];
                    qb           = b[j];
                    d[2*j +: 2]  = {qa, qa ^ qb};
                    if (!qb)
                    begin
                        // Bits above this level are no longer looked at, so
                        // the whole word may be complemented.
                        if (qa)
                        begin
                            a = ~a;
                            b = ~b;
                        end
                        t = a;
                        a = b;
                        b = t;
                    end
                end
            end
            if (ok)
            begin
                res_next.index_out = hcim_pkg::INDEX_W'(d);
                res_next.valid_res = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= KW'(RST_ORDER);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                k_reg <= k_next;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg <= req.data;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_reg <= res_next;
        end
    end

endmodule

FILE: rtl/core/hcim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcim_checker
// Port-level checks for the Hilbert curve index mapper, bound to the top level.
// ----------------------------------------------------------------------------
module hcim_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input hcim_pkg::rsp_t rsp_data
);

    // A stalled result must not change or disappear.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // An invalid result carries only zeros.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.valid_res |->
            rsp_data.x_out == '0 && rsp_data.y_out == '0 && rsp_data.index_out == '0)
        else $error("invalid result with nonzero fields");

    // A result holds either a cell or an index, never both.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.index_out != '0 |->
            rsp_data.x_out == '0 && rsp_data.y_out == '0)
        else $error("result carries both a cell and an index");

    // A rise of rsp_valid follows a request transfer through the input register
    // and then the result register, as an empty output cannot stall between them.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a matching request transfer");

endmodule

bind hilbert_curve_index_mapper hcim_checker u_hcim_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

FILE: tb/hilbert_curve_index_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_curve_index_mapper_tb
// Self-checking regression for the Hilbert curve index mapper. Requests in
// both directions are sent over the request channel in random bursts while
// the result channel stalls on its own schedule. Each transfer is predicted
// by an independent Hilbert walk at the current curve order, and each result
// is compared field by field against the oldest prediction. The curve order
// is rewritten between phases, including the saturating values.
// ----------------------------------------------------------------------------
module hilbert_curve_index_mapper_tb;

    localparam int          MAX_ORDER  = 8;
    localparam int          RAND_ITEMS = 40;
    localparam int unsigned RUN_LIMIT  = 2_000_000;

    typedef enum int
    {
        SINK_OPEN,
        SINK_COIN,
        SINK_LIGHT,
        SINK_TRICKLE
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    hcim_cfg_if cfg_ch();
    hcim_req_if req_ch();
    hcim_rsp_if rsp_ch();

    hilbert_curve_index_mapper #(
        .MAX_ORDER(MAX_ORDER)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    hcim_pkg::rsp_t                 pending_results[$];
    logic [hcim_pkg::ORDER_W-1:0]   order_reg = 4'd8;
    int                   fail_count = 0;
    int                   result_count = 0;
    int                   to_point_count = 0;
    int                   to_index_count = 0;
    int                   outside_count = 0;
    int                   order_writes = 0;
    int                   burst_left = 0;
    bit                   steady_send = 1'b0;
    bit                   sink_forced = 1'b0;
    sink_mode_t           sink_mode = SINK_OPEN;
    int                   sink_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // For a quadrant with qb low, transposes the sub-square, reflecting it first if qa is set.
    function automatic void turn_quadrant(input int unsigned s, input int unsigned qa,
                                          input int unsigned qb, inout int unsigned a,
                                          inout int unsigned b);
        int unsigned tmp;
        if (qb == 0)
        begin
            if (qa == 1)
            begin
                a = s - 1 - a;
                b = s - 1 - b;
            end
            tmp = a;
            a   = b;
            b   = tmp;
        end
    endfunction

    function automatic hcim_pkg::rsp_t hilbert_map(input hcim_pkg::req_t r,
                                                   input logic [hcim_pkg::ORDER_W-1:0] ord);
        int unsigned    k, side, s, t, a, b, qa, qb, d;
        hcim_pkg::rsp_t res;
        k    = (ord < 1) ? 1 : (ord > MAX_ORDER) ? MAX_ORDER : ord;
        side = 1 << k;
        res  = '0;
        if (r.op == hcim_pkg::OP_TO_POINT)
        begin
            if (r.curve_index < side * side)
            begin
                a = 0;
                b = 0;
                t = r.curve_index;
                // Walk up from the finest level; each digit pair picks a quadrant.
                for (s = 1; s < side; s = s << 1)
                begin
                    qa = (t >> 1) & 1;
                    qb = (t ^ qa) & 1;
                    turn_quadrant(s, qa, qb, a, b);
                    a = a + s * qa;
                    b = b + s * qb;
                    t = t >> 2;
                end
                res.x_out     = hcim_pkg::COORD_W'(b);
                res.y_out     = hcim_pkg::COORD_W'(a);
                res.valid_res = 1'b1;
            end
        end
        else if (r.x_coord < side && r.y_coord < side)
        begin
            a = r.y_coord;
            b = r.x_coord;
            d = 0;
            for (s = side >> 1; s > 0; s = s >> 1)
            begin
                qa = ((a & s) != 0) ? 1 : 0;
                qb = ((b & s) != 0) ? 1 : 0;
                d  = d + s * s * ((3 * qa) ^ qb);
                turn_quadrant(side, qa, qb, a, b);
            end
            res.index_out = hcim_pkg::INDEX_W'(d);
            res.valid_res = 1'b1;
        end
        return res;
    endfunction

    function automatic hcim_pkg::req_t make_point(input int unsigned idx);
        hcim_pkg::req_t r;
        r.op          = hcim_pkg::OP_TO_POINT;
        r.curve_index = hcim_pkg::INDEX_W'(idx);
        r.x_coord     = hcim_pkg::COORD_W'($urandom);
        r.y_coord     = hcim_pkg::COORD_W'($urandom);
        return r;
    endfunction

    function automatic hcim_pkg::req_t make_cell(input int unsigned x, input int unsigned y);
        hcim_pkg::req_t r;
        r.op          = hcim_pkg::OP_TO_INDEX;
        r.curve_index = hcim_pkg::INDEX_W'($urandom);
        r.x_coord     = hcim_pkg::COORD_W'(x);
        r.y_coord     = hcim_pkg::COORD_W'(y);
        return r;
    endfunction

    // Mostly in-range requests at the current order, with some that fall off
    // the curve or the grid.
    function automatic hcim_pkg::req_t random_request();
        int unsigned k, side;
        k    = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        side = 1 << k;
        if ($urandom_range(0, 1) == 0)
        begin
            if ($urandom_range(0, 4) != 0)
                return make_point($urandom_range(0, side * side - 1));
            return make_point($urandom_range(0, 65535));
        end
        if ($urandom_range(0, 4) != 0)
            return make_cell($urandom_range(0, side - 1), $urandom_range(0, side - 1));
        return make_cell($urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic pace_sender();
        int gap;
        if (steady_send)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap        = $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_request(input hcim_pkg::req_t r);
        hcim_pkg::rsp_t want;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        want = hilbert_map(r, order_reg);
        pending_results.push_back(want);
        if (r.op == hcim_pkg::OP_TO_POINT)
            to_point_count++;
        else
            to_index_count++;
        if (!want.valid_res)
            outside_count++;
        pace_sender();
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_order(input logic [hcim_pkg::ORDER_W-1:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        order_reg = value;
        order_writes++;
    endtask

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 80);
        end
        else
            sink_left--;
        if (sink_forced)
            rsp_ch.ready <= 1'b1;
        else
            case (sink_mode)
                SINK_OPEN:    rsp_ch.ready <= 1'b1;
                SINK_COIN:    rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                SINK_LIGHT:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_TRICKLE: rsp_ch.ready <= ((sink_left % 8) < 2);
                default:      rsp_ch.ready <= 1'b1;
            endcase
    end

    always @(posedge clk)
    begin
        hcim_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.data.x_out !== want.x_out)
                begin
                    $error("x_out mismatch: expected %0d, actual %0d",
                           want.x_out, rsp_ch.data.x_out);
                    fail_count++;
                end
                if (rsp_ch.data.y_out !== want.y_out)
                begin
                    $error("y_out mismatch: expected %0d, actual %0d",
                           want.y_out, rsp_ch.data.y_out);
                    fail_count++;
                end
                if (rsp_ch.data.index_out !== want.index_out)
                begin
                    $error("index_out mismatch: expected %0d, actual %0d",
                           want.index_out, rsp_ch.data.index_out);
                    fail_count++;
                end
                if (rsp_ch.data.valid_res !== want.valid_res)
                begin
                    $error("valid_res mismatch: expected %0d, actual %0d",
                           want.valid_res, rsp_ch.data.valid_res);
                    fail_count++;
                end
            end
        end
    end

    // Order after reset: corners of the grid and both ends of the curve.
    task automatic test_reset_order();
        send_request(make_point(0));
        send_request(make_point(1));
        send_request(make_point(65535));
        send_request(make_point(32768));
        send_request(make_cell(0, 0));
        send_request(make_cell(255, 255));
        send_request(make_cell(255, 0));
        send_request(make_cell(0, 255));
    endtask

    // Smallest grid, then the values that saturate to the smallest and largest.
    task automatic test_order_extremes();
        write_order(4'd1);
        for (int i = 0; i < 5; i++)
            send_request(make_point(i));
        send_request(make_cell(0, 0));
        send_request(make_cell(1, 0));
        send_request(make_cell(1, 1));
        send_request(make_cell(0, 1));
        send_request(make_cell(2, 0));
        send_request(make_cell(0, 2));
        write_order(4'd0);
        send_request(make_point(3));
        send_request(make_point(4));
        send_request(make_cell(1, 1));
        write_order(4'd15);
        send_request(make_point(65535));
        send_request(make_cell(255, 255));
    endtask

    // Full rate on both sides, then into a stalling receiver, then a drain and random bursts.
    task automatic test_back_to_back();
        write_order(4'd8);
        steady_send = 1'b1;
        sink_forced = 1'b1;
        for (int i = 0; i < 60; i++)
            send_request(random_request());
        sink_forced = 1'b0;
        for (int i = 0; i < 40; i++)
            send_request(random_request());
        steady_send = 1'b0;
        drain_results();
        for (int i = 0; i < 20; i++)
            send_request(random_request());
    endtask

    task automatic test_random_sweep();
        logic [hcim_pkg::ORDER_W-1:0] sweep[10];
        sweep = '{4'd3, 4'd8, 4'd1, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd0, 4'd9};
        foreach (sweep[p])
        begin
            // The last phase uses a random over-range value to cover saturation.
            if (p == 9)
                write_order(hcim_pkg::ORDER_W'($urandom_range(9, 15)));
            else
                write_order(sweep[p]);
            for (int i = 0; i < RAND_ITEMS; i++)
                send_request(random_request());
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_order();
        test_order_extremes();
        test_back_to_back();
        test_random_sweep();

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d index-to-cell and %0d cell-to-index transfers, %0d off the grid.",
                 to_point_count, to_index_count, outside_count);
        $display("Checked %0d results across %0d curve order writes.",
                 result_count, order_writes);
        if (fail_count == 0)
            $display("hilbert_curve_index_mapper regression: pass");
        else
            $display("hilbert_curve_index_mapper regression: fail");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Run timed out with %0d results outstanding.", pending_results.size());
        $display("hilbert_curve_index_mapper regression: fail");
        $finish;
    end

endmodule
